@@ rtl/lrs_pkg.sv @@
package lrs_pkg;

    // Default width of the time base.
    localparam int DEF_TIME_WIDTH = 32;

    // Field widths.
    localparam int NOW_W   = 32;
    localparam int WAIT_W  = 17;
    localparam int REG16_W = 16;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Reset values of the configuration registers and of the retry wait.
    localparam logic [REG16_W-1:0] RST_INIT_WAIT = 16'd5000;
    localparam logic [REG16_W-1:0] RST_THRESHOLD = 16'd30000;
    localparam logic [WAIT_W-1:0]  RST_CAP       = 17'd60000;
    localparam logic [REG16_W-1:0] RST_TIMEOUT   = 16'd30000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_INIT_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd3;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_STOP  = 2'd1,
        OP_POLL  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        MODE_DISABLED   = 3'd0,
        MODE_CONNECTING = 3'd1,
        MODE_ONLINE     = 3'd2,
        MODE_RETRY      = 3'd3,
        MODE_FAULT      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_CREDS   = 3'd1,
        ERR_START   = 3'd2,
        ERR_STOP    = 3'd3,
        ERR_TIMEOUT = 3'd4
    } err_t;

    // One request as held in the input register.
    typedef struct packed {
        logic [1:0]       operation;
        logic [NOW_W-1:0] now_time;
        logic             creds_valid;
        logic             driver_start_ok;
        logic             driver_stop_ok;
        logic             driver_online;
    } item_t;

    // Configuration register set.
    typedef struct packed {
        logic [REG16_W-1:0] initial_retry_wait;
        logic [REG16_W-1:0] backoff_threshold;
        logic [WAIT_W-1:0]  backoff_cap;
        logic [REG16_W-1:0] connect_timeout;
    } cfg_t;

    // One result.
    typedef struct packed {
        logic  request_ok;
        err_t  last_error;
        mode_t link_state;
    } result_t;

endpackage

@@ rtl/lrs_core.sv @@
module lrs_core #(
    parameter int TIME_WIDTH = lrs_pkg::DEF_TIME_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  lrs_pkg::item_t   item,
    input  lrs_pkg::cfg_t    cfg,
    output lrs_pkg::result_t result
);
    import lrs_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > WAIT_W) ? TIME_WIDTH : WAIT_W;

    mode_t                 mode_reg, mode_next;
    err_t                  err_reg, err_next;
    logic [TIME_WIDTH-1:0] since_reg, since_next;
    logic [WAIT_W-1:0]     wait_reg, wait_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  wait_done;
    logic                  timeout_hit;
    logic                  ok;

    // Time difference since the last change, wrapping with the time base.
    assign now_t       = TIME_WIDTH'(item.now_time);
    assign elapsed     = now_t - since_reg;
    assign wait_done   = CMP_W'(elapsed) >= CMP_W'(wait_reg);
    assign timeout_hit = CMP_W'(elapsed) >= CMP_W'(cfg.connect_timeout);

    // State registers advance once per processed transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_DISABLED;
            err_reg   <= ERR_NONE;
            since_reg <= '0;
            wait_reg  <= WAIT_W'(RST_INIT_WAIT);
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            err_reg   <= err_next;
            since_reg <= since_next;
            wait_reg  <= wait_next;
        end
    end

    // Next state for the current request.
    always_comb
    begin
        mode_next  = mode_reg;
        err_next   = err_reg;
        since_next = since_reg;
        wait_next  = wait_reg;
        ok         = 1'b0;

        case (item.operation)
            OP_BEGIN:
            begin
                if (!item.creds_valid)
                begin
                    err_next = ERR_CREDS;
                end
                else if (mode_reg != MODE_DISABLED && !item.driver_stop_ok)
                begin
                    // The stop before restarting failed.
                    mode_next = MODE_FAULT;
                    err_next  = ERR_STOP;
                end
                else
                begin
                    wait_next = WAIT_W'(cfg.initial_retry_wait);
                    if (item.driver_start_ok)
                    begin
                        since_next = now_t;
                        mode_next  = MODE_CONNECTING;
                        err_next   = ERR_NONE;
                        ok         = 1'b1;
                    end
                    else if (!item.driver_stop_ok)
                    begin
                        mode_next = MODE_FAULT;
                        err_next  = ERR_STOP;
                    end
                    else
                    begin
                        mode_next  = MODE_RETRY;
                        since_next = now_t;
                        err_next   = ERR_START;
                    end
                end
            end
            OP_STOP:
            begin
                if (mode_reg != MODE_DISABLED && !item.driver_stop_ok)
                begin
                    mode_next = MODE_FAULT;
                    err_next  = ERR_STOP;
                end
                else
                begin
                    mode_next = MODE_DISABLED;
                    err_next  = ERR_NONE;
                    ok        = 1'b1;
                end
            end
            OP_POLL:
            begin
                case (mode_reg)
                    MODE_RETRY:
                    begin
                        if (wait_done)
                        begin
                            // Back off: double below the threshold, else jump to the cap.
                            if (wait_reg >= WAIT_W'(cfg.backoff_threshold))
                                wait_next = cfg.backoff_cap;
                            else
                                wait_next = {wait_reg[WAIT_W-2:0], 1'b0};
                            if (item.driver_start_ok)
                            begin
                                since_next = now_t;
                                mode_next  = MODE_CONNECTING;
                                err_next   = ERR_NONE;
                            end
                            else if (!item.driver_stop_ok)
                            begin
                                mode_next = MODE_FAULT;
                                err_next  = ERR_STOP;
                            end
                            else
                            begin
                                mode_next  = MODE_RETRY;
                                since_next = now_t;
                                err_next   = ERR_START;
                            end
                        end
                    end
                    MODE_CONNECTING, MODE_ONLINE:
                    begin
                        if (item.driver_online)
                        begin
                            mode_next = MODE_ONLINE;
                            err_next  = ERR_NONE;
                            wait_next = WAIT_W'(cfg.initial_retry_wait);
                        end
                        else if (mode_reg == MODE_ONLINE || timeout_hit)
                        begin
                            // Link dropped or connect attempt timed out.
                            if (!item.driver_stop_ok)
                            begin
                                mode_next = MODE_FAULT;
                                err_next  = ERR_STOP;
                            end
                            else
                            begin
                                mode_next  = MODE_RETRY;
                                since_next = now_t;
                                err_next   = (mode_reg == MODE_ONLINE) ? ERR_NONE
                                                                       : ERR_TIMEOUT;
                            end
                        end
                    end
                    default:
                    begin
                        // Disabled and fault ignore polls.
                    end
                endcase
            end
            default:
            begin
                // Unused operation code changes nothing.
            end
        endcase
    end

    assign result.link_state = mode_next;
    assign result.last_error = err_next;
    assign result.request_ok = ok;

endmodule

@@ rtl/link_retry_supervisor.sv @@
// Channel   Direction  Handshake                 Content
// s_axis    in         s_tvalid / s_tready       one request (tuser operation, tdata fields)
// m_axis    out        m_tvalid / m_tready       one result per request
// cfg       in         cfg_write                 register write, no read-back
//
// A request is held in the input register, where lrs_core evaluates it
// against the state registers; the result is registered in the output register at
// the same edge as the state update, so one transaction per cycle is sustained while
// m_tready does not stall the output. Reset is asynchronous, active low, and restores
// the configuration defaults and the disabled state. An m_tready stall holds the output
// and then the input register; s_tready drops when both are full and m_tready is low.
module link_retry_supervisor #(
    parameter int TIME_WIDTH = lrs_pkg::DEF_TIME_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,   // operation
    // now_time[31:0], creds_valid, driver_start_ok, driver_stop_ok,
    // driver_online, zero fill
    input  logic [39:0]                    s_tdata,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // link_state[2:0], last_error[2:0],
                                                      // request_ok, zero fill
    // Configuration port.
    input  logic                           cfg_write,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]      cfg_data
);
    import lrs_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    cfg_t    cfg_reg;
    result_t step_result;
    logic    advance;
    logic    s_accept;

    // Pipeline control: the input register drains whenever the output has room.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and output payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.operation       <= s_tuser;
            in_item_reg.now_time        <= s_tdata[31:0];
            in_item_reg.creds_valid     <= s_tdata[32];
            in_item_reg.driver_start_ok <= s_tdata[33];
            in_item_reg.driver_stop_ok  <= s_tdata[34];
            in_item_reg.driver_online   <= s_tdata[35];
        end
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_retry_wait <= RST_INIT_WAIT;
            cfg_reg.backoff_threshold  <= RST_THRESHOLD;
            cfg_reg.backoff_cap        <= RST_CAP;
            cfg_reg.connect_timeout    <= RST_TIMEOUT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_INIT_WAIT: cfg_reg.initial_retry_wait <= cfg_data[REG16_W-1:0];
                REG_THRESHOLD: cfg_reg.backoff_threshold  <= cfg_data[REG16_W-1:0];
                REG_CAP:       cfg_reg.backoff_cap        <= cfg_data[WAIT_W-1:0];
                REG_TIMEOUT:   cfg_reg.connect_timeout    <= cfg_data[REG16_W-1:0];
                default:       cfg_reg.connect_timeout    <= cfg_reg.connect_timeout;
            endcase
        end
    end

    lrs_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg.request_ok, out_result_reg.last_error,
                       out_result_reg.link_state};

    // A processed request always shows up on the result channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("processed request did not reach the output register");

    // A held request is not dropped while the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("stalled request was lost");

    // A successful request leaves the link connecting or disabled.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_result.request_ok |->
            (step_result.link_state == MODE_CONNECTING ||
             step_result.link_state == MODE_DISABLED))
        else $error("request_ok with unexpected link state");

endmodule
